>>> rtl/ordered_array_insert_erase_unit_defines.svh
// Assertion macros shared by the ordered array insert/erase RTL.
`ifndef ORDERED_ARRAY_INSERT_ERASE_UNIT_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_ERASE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define OAIE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check a property on every clock edge, reset included.
`define OAIE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define OAIE_ASSERT(lbl, prop, msg)
`define OAIE_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> rtl/oaie_pkg.sv
// Types and constants of the ordered array insert/erase unit.
package oaie_pkg;

	// Array depth; position and count fields are five bits wide.
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int OP_W  = 3;
	localparam int POS_W = 5;
	localparam int CNT_W = 5;
	localparam int ST_W  = 2;

	localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(DEPTH);

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
	localparam logic [OP_W-1:0] OP_ERASE      = 3'd3;
	localparam logic [OP_W-1:0] OP_READ       = 3'd4;

	// Status codes
	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// Command broadcast to every cell of the row
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_ERASE,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [POS_W-1:0] pos;
	} cell_cmd_t;

	// Result of decoding one word against the current count
	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [CNT_W-1:0] count;
		logic             rd_hit;
	} ctrl_res_t;

endpackage

>>> rtl/oaie_if.sv
// Request and response channel interfaces of the ordered array unit.
interface oaie_req_if #(
	parameter int DATA_WIDTH = 32
);
	logic                              valid;
	logic                              ready;
	logic [oaie_pkg::OP_W-1:0]         operation;
	logic [oaie_pkg::POS_W-1:0]        position;
	logic signed [DATA_WIDTH-1:0]      value;

	modport source (output valid, output operation, output position, output value,
		input ready);
	modport sink (input valid, input operation, input position, input value,
		output ready);
endinterface

interface oaie_rsp_if #(
	parameter int DATA_WIDTH = 32
);
	logic                              valid;
	logic                              ready;
	logic signed [DATA_WIDTH-1:0]      read_value;
	logic [oaie_pkg::CNT_W-1:0]        count;
	logic [oaie_pkg::ST_W-1:0]         status;

	modport source (output valid, output read_value, output count, output status,
		input ready);
	modport sink (input valid, input read_value, input count, input status,
		output ready);
endinterface

>>> rtl/ordered_array_insert_erase_unit.sv
// Top level of the ordered array insert/erase unit.
//
// Request channel (req): one word per operation: push front, push back,
// insert at position, erase at position or read at position, with the value
// stored by pushes and inserts. Response channel (rsp): one word per request
// with the status, the entry count after the operation and, for a read that
// hits, the entry value (zero otherwise).
//
// A row of DEPTH cells holds the entries in order; on an insert or erase every
// cell at or above the position shifts by one slot in the cycle the request
// is taken. The response is registered and appears in the cycle after the
// request is taken, and one request is taken per cycle as long as the
// response side keeps up; the response register lets a new request in
// during the cycle the previous response is taken.
//
// Reset clears the entry count and the response valid flag; cell contents are
// left as they are and are only read below the count. While the receiver
// stalls, the pending response holds and req.ready stays low.
`include "ordered_array_insert_erase_unit_defines.svh"

module ordered_array_insert_erase_unit #(
	parameter int DATA_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	oaie_req_if.sink        req,
	oaie_rsp_if.source      rsp
);

	logic                         accept;
	oaie_pkg::cell_cmd_t          cmd;
	oaie_pkg::ctrl_res_t          res;
	logic signed [DATA_WIDTH-1:0] cell_word [oaie_pkg::DEPTH];
	logic signed [DATA_WIDTH-1:0] rd_word;

	logic                         rsp_valid_q;
	logic signed [DATA_WIDTH-1:0] rsp_read_value_q;
	logic [oaie_pkg::CNT_W-1:0]   rsp_count_q;
	logic [oaie_pkg::ST_W-1:0]    rsp_status_q;

	// Take a word whenever the response slot is free or being emptied
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	oaie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (req.operation),
		.position  (req.position),
		.cmd       (cmd),
		.res       (res)
	);

	// Build the row of cells, each wired to its two neighbors
	for (genvar i = 0; i < oaie_pkg::DEPTH; i++) begin : g_cell
		logic signed [DATA_WIDTH-1:0] left_word;
		logic signed [DATA_WIDTH-1:0] right_word;

		if (i == 0) begin : g_first
			assign left_word = '0;
		end else begin : g_left
			assign left_word = cell_word[i-1];
		end

		if (i == oaie_pkg::DEPTH - 1) begin : g_last
			assign right_word = '0;
		end else begin : g_right
			assign right_word = cell_word[i+1];
		end

		oaie_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.new_word   (req.value),
			.left_word  (left_word),
			.right_word (right_word),
			.word       (cell_word[i])
		);
	end

	// Select the read tap; a hit implies the position is below the depth
	assign rd_word = res.rd_hit ? cell_word[req.position[oaie_pkg::IDX_W-1:0]] : '0;

	// Hold the response until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_read_value_q <= rd_word;
			rsp_count_q      <= res.count;
			rsp_status_q     <= res.status;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_read_value_q;
	assign rsp.count      = rsp_count_q;
	assign rsp.status     = rsp_status_q;

	`OAIE_ASSERT(a_accept_responds, accept |=> rsp_valid_q, "accepted word gave no response")
	`OAIE_ASSERT(a_miss_reads_zero, accept && !res.rd_hit |=> rsp_read_value_q == '0, "read value not zero on miss")

endmodule

>>> rtl/oaie_cell.sv
// One slot of the shifting array: holds a word and trades it with its neighbors.
module oaie_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int INDEX      = 0
) (
	input  logic                         clk,
	input  oaie_pkg::cell_cmd_t          cmd,
	input  logic signed [DATA_WIDTH-1:0] new_word,
	input  logic signed [DATA_WIDTH-1:0] left_word,
	input  logic signed [DATA_WIDTH-1:0] right_word,
	output logic signed [DATA_WIDTH-1:0] word
);

	localparam logic [oaie_pkg::POS_W-1:0] SLOT = oaie_pkg::POS_W'(INDEX);

	logic signed [DATA_WIDTH-1:0] word_q;
	logic signed [DATA_WIDTH-1:0] word_nxt;

	// Pick the next word: take from the left above an insert point and the new word at it,
	// from the right at and above an erase point, else hold
	always_comb begin
		word_nxt = word_q;
		case (cmd.kind)
			oaie_pkg::CMD_INSERT: begin
				if (SLOT > cmd.pos) begin
					word_nxt = left_word;
				end else if (SLOT == cmd.pos) begin
					word_nxt = new_word;
				end
			end
			oaie_pkg::CMD_ERASE: begin
				if (SLOT >= cmd.pos) begin
					word_nxt = right_word;
				end
			end
			default: begin
				word_nxt = word_q;
			end
		endcase
	end

	// Store the word
	always_ff @(posedge clk) begin
		word_q <= word_nxt;
	end

	assign word = word_q;

endmodule

>>> rtl/oaie_ctrl.sv
// Operation decoder and entry count of the ordered array unit.
`include "ordered_array_insert_erase_unit_defines.svh"

module oaie_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [oaie_pkg::OP_W-1:0]     operation,
	input  logic [oaie_pkg::POS_W-1:0]    position,
	output oaie_pkg::cell_cmd_t           cmd,
	output oaie_pkg::ctrl_res_t           res
);

	logic [oaie_pkg::CNT_W-1:0] count_q;
	logic [oaie_pkg::CNT_W-1:0] count_nxt;
	logic                       full;
	oaie_pkg::cell_cmd_t        cmd_dec;
	logic [oaie_pkg::ST_W-1:0]  status;

	assign full = (count_q == oaie_pkg::COUNT_MAX);

	// Decode the operation against the current count
	always_comb begin
		cmd_dec.kind = oaie_pkg::CMD_HOLD;
		cmd_dec.pos  = position;
		status       = oaie_pkg::ST_DONE;
		case (operation)
			oaie_pkg::OP_PUSH_FRONT: begin
				cmd_dec.pos = '0;
				if (full) begin
					status = oaie_pkg::ST_FULL;
				end else begin
					cmd_dec.kind = oaie_pkg::CMD_INSERT;
				end
			end
			oaie_pkg::OP_PUSH_BACK: begin
				cmd_dec.pos = oaie_pkg::POS_W'(count_q);
				if (full) begin
					status = oaie_pkg::ST_FULL;
				end else begin
					cmd_dec.kind = oaie_pkg::CMD_INSERT;
				end
			end
			oaie_pkg::OP_INSERT: begin
				if (position > oaie_pkg::POS_W'(count_q)) begin
					status = oaie_pkg::ST_RANGE;
				end else if (full) begin
					status = oaie_pkg::ST_FULL;
				end else begin
					cmd_dec.kind = oaie_pkg::CMD_INSERT;
				end
			end
			oaie_pkg::OP_ERASE: begin
				if (position >= oaie_pkg::POS_W'(count_q)) begin
					status = oaie_pkg::ST_RANGE;
				end else begin
					cmd_dec.kind = oaie_pkg::CMD_ERASE;
				end
			end
			oaie_pkg::OP_READ: begin
				if (position >= oaie_pkg::POS_W'(count_q)) begin
					status = oaie_pkg::ST_RANGE;
				end else begin
					cmd_dec.kind = oaie_pkg::CMD_READ;
				end
			end
			default: begin
				status = oaie_pkg::ST_RANGE;
			end
		endcase
	end

	// Gate the command with the handshake
	always_comb begin
		cmd = cmd_dec;
		if (!accept) begin
			cmd.kind = oaie_pkg::CMD_HOLD;
		end
	end

	// Advance the count
	always_comb begin
		case (cmd_dec.kind)
			oaie_pkg::CMD_INSERT: count_nxt = count_q + 1'b1;
			oaie_pkg::CMD_ERASE:  count_nxt = count_q - 1'b1;
			default:              count_nxt = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	assign res.status = status;
	assign res.count  = count_nxt;
	assign res.rd_hit = (cmd_dec.kind == oaie_pkg::CMD_READ);

	`OAIE_ASSERT(a_count_bound, count_q <= oaie_pkg::COUNT_MAX, "count above depth")
	`OAIE_ASSERT(a_insert_grows, cmd.kind == oaie_pkg::CMD_INSERT |=> count_q == $past(count_q) + 1'b1, "insert did not grow count")
	`OAIE_ASSERT(a_refused_holds, accept && status != oaie_pkg::ST_DONE |=> count_q == $past(count_q), "refused word changed count")

endmodule

>>> dv/oaie_array_checker.sv
// Checker for the ordered array unit: predicts each response word and compares it.
`timescale 1ns / 100ps

module oaie_array_checker (
	input  logic  clk,
	input  logic  arst_n,
	oaie_req_if   req,
	oaie_rsp_if   rsp,
	output int    mismatches,
	output int    pending
);
	import oaie_pkg::*;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [CNT_W-1:0]   count;
		logic [ST_W-1:0]    status;
	} array_rsp_t;

	// Shadow copy of the array contents and its fill level
	logic signed [31:0] slots [DEPTH];
	int                 fill;
	array_rsp_t         rsp_queue [$];

	// Apply one operation to the shadow array and return the response word
	function automatic array_rsp_t apply_operation(logic [OP_W-1:0] op,
			logic [POS_W-1:0] pos, logic signed [31:0] val);
		array_rsp_t res;
		int         p;
		int         at;
		logic       full;
		logic       do_insert;
		res        = '0;
		res.status = ST_DONE;
		p          = int'(pos);
		at         = 0;
		full       = (fill >= DEPTH);
		do_insert  = 1'b0;
		case (op)
			OP_PUSH_FRONT: begin
				if (full) res.status = ST_FULL;
				else begin
					at        = 0;
					do_insert = 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (full) res.status = ST_FULL;
				else begin
					at        = fill;
					do_insert = 1'b1;
				end
			end
			OP_INSERT: begin
				// range check wins over the full check
				if (p > fill) res.status = ST_RANGE;
				else if (full) res.status = ST_FULL;
				else begin
					at        = p;
					do_insert = 1'b1;
				end
			end
			OP_ERASE: begin
				if (p >= fill) res.status = ST_RANGE;
				else begin
					// close the gap
					for (int i = p; i + 1 < fill; i++)
						slots[i] = slots[i + 1];
					fill--;
				end
			end
			OP_READ: begin
				if (p >= fill) res.status = ST_RANGE;
				else res.read_value = slots[p];
			end
			default: res.status = ST_RANGE;
		endcase
		if (do_insert) begin
			// open a gap and store the word
			for (int i = fill; i > at; i--)
				slots[i] = slots[i - 1];
			slots[at] = val;
			fill++;
		end
		res.count = CNT_W'(fill);
		return res;
	endfunction

	// Compare accepted responses, then record the prediction for an accepted request
	always @(posedge clk or negedge arst_n) begin
		array_rsp_t exp_word;
		int         errs;
		if (!arst_n) begin
			fill = 0;
			mismatches <= 0;
			pending    <= 0;
			rsp_queue.delete();
		end else begin
			errs = 0;
			if (rsp.valid && rsp.ready) begin
				if (rsp_queue.size() == 0) begin
					$error("response word with no request pending");
					errs++;
				end else begin
					exp_word = rsp_queue.pop_front();
					if (rsp.read_value !== exp_word.read_value) begin
						$error("read_value: expected %0d, got %0d",
							exp_word.read_value, rsp.read_value);
						errs++;
					end
					if (rsp.count !== exp_word.count) begin
						$error("count: expected %0d, got %0d", exp_word.count, rsp.count);
						errs++;
					end
					if (rsp.status !== exp_word.status) begin
						$error("status: expected %0d, got %0d", exp_word.status, rsp.status);
						errs++;
					end
				end
			end
			if (req.valid && req.ready)
				rsp_queue.insert(rsp_queue.size(),
					apply_operation(req.operation, req.position, req.value));
			mismatches <= mismatches + errs;
			pending    <= rsp_queue.size();
		end
	end

endmodule

>>> dv/tb_ordered_array_insert_erase_unit.sv
// Top of the ordered array unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_ordered_array_insert_erase_unit;
	import oaie_pkg::*;

	localparam int                RANDOM_WORDS = 1500;
	localparam logic [OP_W-1:0]   OP_BAD_FIRST = 3'd5;
	localparam logic [OP_W-1:0]   OP_BAD_LAST  = 3'd7;
	localparam logic signed [31:0] VAL_MIN     = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX     = 32'sh7fff_ffff;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIXED
	} traffic_mode_t;

	logic          clk;
	logic          arst_n;
	int            mismatches;
	int            pending;
	int            src_idle;
	int            dst_idle;
	traffic_mode_t mode;

	oaie_req_if req_ch ();
	oaie_rsp_if rsp_ch ();

	ordered_array_insert_erase_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	oaie_array_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stall the response side at random
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= dst_idle);

	// Present one request word, idling first at random, and hold it until taken
	task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
			logic signed [31:0] val);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.position  <= pos;
		req_ch.value     <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Pick a random operation weighted by the current traffic mode
	function automatic logic [OP_W-1:0] pick_operation(traffic_mode_t m);
		int roll;
		roll = $urandom_range(99);
		if (roll < 5) return OP_W'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST));
		case (m)
			MODE_FILL: begin
				if (roll < 35) return OP_PUSH_BACK;
				if (roll < 55) return OP_PUSH_FRONT;
				if (roll < 80) return OP_INSERT;
				if (roll < 88) return OP_ERASE;
				return OP_READ;
			end
			MODE_DRAIN: begin
				if (roll < 55) return OP_ERASE;
				if (roll < 80) return OP_READ;
				if (roll < 90) return OP_PUSH_BACK;
				return OP_INSERT;
			end
			default: begin
				if (roll < 20) return OP_PUSH_BACK;
				if (roll < 30) return OP_PUSH_FRONT;
				if (roll < 50) return OP_INSERT;
				if (roll < 70) return OP_ERASE;
				return OP_READ;
			end
		endcase
	endfunction

	// Mostly plausible indexes, now and then any five-bit value
	function automatic logic [POS_W-1:0] pick_position();
		if ($urandom_range(99) < 85) return POS_W'($urandom_range(DEPTH));
		return POS_W'($urandom);
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(39))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2:       return 32'sd0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Stimulus and verdict
	initial begin
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = OP_PUSH_FRONT;
		req_ch.position  = '0;
		req_ch.value     = '0;
		rsp_ch.ready     = 1'b0;
		src_idle         = 16;
		dst_idle         = 75;
		mode             = MODE_FILL;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty array, bad codes, both extremes of the word
		send_word(OP_READ, 5'd0, 32'sd1);
		send_word(OP_ERASE, 5'd0, 32'sd0);
		send_word(OP_INSERT, 5'd1, 32'sd7);
		send_word(OP_BAD_LAST, 5'd0, 32'sd0);
		send_word(OP_INSERT, 5'd0, VAL_MAX);
		send_word(OP_PUSH_FRONT, 5'd31, VAL_MIN);
		send_word(OP_PUSH_BACK, 5'd0, -32'sd1);
		send_word(OP_INSERT, 5'd3, 32'sd0);
		send_word(OP_INSERT, 5'd1, 32'sh5555_5555);
		send_word(OP_READ, 5'd4, 32'sd0);
		send_word(OP_ERASE, 5'd2, 32'sd0);
		send_word(OP_READ, 5'd31, 32'sd0);
		send_word(OP_BAD_FIRST, 5'd0, 32'sd0);
		send_word(OP_BAD_FIRST + 3'd1, 5'd1, -32'sd1);
		// fill to the top, then hit the full and range checks
		for (int i = 4; i < DEPTH; i++)
			send_word(OP_PUSH_BACK, 5'd0, 32'(i) * 32'sh1357_9bdf);
		send_word(OP_PUSH_FRONT, 5'd0, 32'sd9);
		send_word(OP_INSERT, 5'd16, 32'sd9);
		send_word(OP_INSERT, 5'd17, 32'sd9);
		send_word(OP_READ, 5'd15, 32'sd0);
		send_word(OP_ERASE, 5'd15, 32'sd0);

		// random traffic in three idling phases
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 3) begin
				src_idle = 75;
				dst_idle = 16;
			end else if (n == 2 * RANDOM_WORDS / 3) begin
				src_idle = 0;
				dst_idle = 0;
			end
			if (n % 40 == 0) mode = traffic_mode_t'($urandom_range(2));
			send_word(pick_operation(mode), pick_position(), pick_value());
		end
		@(negedge clk);
		req_ch.valid <= 1'b0;

		// drain the outstanding responses, then idle before the verdict
		for (int w = 0; w < 5000 && pending != 0; w++) @(posedge clk);
		repeat (4) @(posedge clk);
		if (pending != 0)
			$error("%0d response words never arrived", pending);
		if (mismatches == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/oaie_pkg.sv
rtl/oaie_if.sv
rtl/oaie_cell.sv
rtl/oaie_ctrl.sv
rtl/ordered_array_insert_erase_unit.sv
dv/oaie_array_checker.sv
dv/tb_ordered_array_insert_erase_unit.sv
